// ===== rtl/core/amab_pkg.sv =====
// Shared types and constants for the ARGB modulate and alpha blend core.
// Depends on nothing; every module of the core imports it.
`default_nettype none

package amab_pkg;

  // Pixel and channel geometry
  localparam int unsigned PixW     = 32;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned NumChan  = 3;               // color channels: B, G, R
  localparam int unsigned NumAll   = PixW / ChanW;    // color channels plus alpha

  // Blend numerator and quotient widths
  localparam int unsigned NumW     = 17;
  localparam int unsigned QuoW     = 9;

  // Pipeline shape
  localparam int unsigned MixStages    = 3;
  localparam int unsigned DivStages    = 3;
  localparam int unsigned BitsPerStage = QuoW / DivStages;
  localparam int unsigned AmabLatency  = 2 + MixStages + DivStages;

  // Constants
  localparam logic [PixW-1:0]  ModBypass = 32'hFFFF_FFFF;
  localparam logic [ChanW-1:0] AlphaFull = 8'hFF;
  localparam logic [ChanW-1:0] AlphaZero = 8'h00;

  // One input item and one result item
  typedef struct packed {
    logic [PixW-1:0] source_pixel;
    logic [PixW-1:0] dest_pixel;
  } amab_in_t;

  typedef struct packed {
    logic [PixW-1:0] result_pixel;
    logic            write_enable;
  } amab_out_t;

  // Compositing case picked from the source and destination alpha
  typedef enum logic [1:0] {
    CASE_SKIP,
    CASE_COPY,
    CASE_OPAQUE,
    CASE_BLEND
  } amab_case_e;

  // Item state handed from the mix stages through the divider stages
  typedef struct packed {
    logic                              valid;
    amab_case_e                        kind;
    logic [PixW-1:0]                   src;
    logic [PixW-1:0]                   dst;
    logic [ChanW-1:0]                  oa;
    logic [NumChan*ChanW-1:0]          mix;
    logic [NumChan-1:0][NumW-1:0]      rem;
    logic [NumChan-1:0][QuoW-1:0]      quo;
  } amab_div_t;

endpackage

`default_nettype wire

// ===== rtl/core/amab_modulate.sv =====
// First pipeline stage: scales each source channel by the modulation color.
// Depends on amab_pkg.
`default_nettype none

module amab_modulate import amab_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  amab_in_t        item_i,
  input  logic [PixW-1:0] mod_color_i,
  output logic            valid_o,
  output logic [PixW-1:0] src_o,
  output logic [PixW-1:0] dst_o
);

  logic                  valid_q;
  logic [PixW-1:0]       src_d, src_q;
  logic [PixW-1:0]       dst_q;
  logic [2*ChanW-1:0]    prod [NumAll];

  // Scale each channel as (s*m+128)>>8 unless the color is all ones
  always_comb begin
    src_d = item_i.source_pixel;
    for (int c = 0; c < NumAll; c++) begin
      prod[c] = {{ChanW{1'b0}}, item_i.source_pixel[c*ChanW +: ChanW]}
              * {{ChanW{1'b0}}, mod_color_i[c*ChanW +: ChanW]}
              + (2*ChanW)'(128);
      if (mod_color_i != ModBypass) begin
        src_d[c*ChanW +: ChanW] = prod[c][2*ChanW-1:ChanW];
      end
    end
  end

  // Advance the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Hold the pixels
  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    dst_q <= item_i.dest_pixel;
  end

  assign valid_o = valid_q;
  assign src_o   = src_q;
  assign dst_o   = dst_q;

endmodule

`default_nettype wire

// ===== rtl/core/amab_mix.sv =====
// Three stages of products and sums: case select, output alpha, opaque mix
// and the blend numerators for the divider. Depends on amab_pkg.
`default_nettype none

module amab_mix import amab_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [PixW-1:0] src_i,
  input  logic [PixW-1:0] dst_i,
  output amab_div_t       stage_o
);

  localparam int unsigned ProdW = 2 * ChanW;
  localparam int unsigned TriW  = 3 * ChanW;

  // Stage A signals
  logic [ChanW-1:0]  sa, da, inv;
  amab_case_e        kind_a_d;
  logic [ProdW-1:0]  s_sa_a_d [NumChan];
  logic [ProdW-1:0]  d_inv_a_d [NumChan];
  logic [ProdW-1:0]  d_da_a_d [NumChan];
  logic [ProdW-1:0]  da_inv_a_d;

  logic              valid_a_q;
  amab_case_e        kind_a_q;
  logic [PixW-1:0]   src_a_q, dst_a_q;
  logic [ChanW-1:0]  sa_a_q, inv_a_q;
  logic [ProdW-1:0]  s_sa_a_q [NumChan];
  logic [ProdW-1:0]  d_inv_a_q [NumChan];
  logic [ProdW-1:0]  d_da_a_q [NumChan];
  logic [ProdW-1:0]  da_inv_a_q;

  // Stage B signals
  logic [ProdW:0]            oa_sum;
  logic [ChanW-1:0]          oa_b_d;
  logic [ProdW:0]            mix_sum [NumChan];
  logic [NumChan*ChanW-1:0]  mix_b_d;
  logic [TriW-1:0]           t_b_d [NumChan];

  logic                      valid_b_q;
  amab_case_e                kind_b_q;
  logic [PixW-1:0]           src_b_q, dst_b_q;
  logic [ChanW-1:0]          oa_b_q;
  logic [NumChan*ChanW-1:0]  mix_b_q;
  logic [ProdW-1:0]          s_sa_b_q [NumChan];
  logic [TriW-1:0]           t_b_q [NumChan];

  // Stage C signals
  logic [TriW:0]                 t_rnd [NumChan];
  logic [NumW-1:0]               p_c [NumChan];
  logic [NumChan-1:0][NumW-1:0]  num_c_d;

  logic                          valid_c_q;
  amab_case_e                    kind_c_q;
  logic [PixW-1:0]               src_c_q, dst_c_q;
  logic [ChanW-1:0]              oa_c_q;
  logic [NumChan*ChanW-1:0]      mix_c_q;
  logic [NumChan-1:0][NumW-1:0]  num_c_q;

  // Stage A: pick the case and form the first products
  always_comb begin
    sa  = src_i[PixW-1 -: ChanW];
    da  = dst_i[PixW-1 -: ChanW];
    inv = AlphaFull - sa;
    priority if (sa == AlphaZero) begin
      kind_a_d = CASE_SKIP;
    end else if (sa == AlphaFull) begin
      kind_a_d = CASE_COPY;
    end else if (da == AlphaFull) begin
      kind_a_d = CASE_OPAQUE;
    end else begin
      kind_a_d = CASE_BLEND;
    end
    for (int c = 0; c < NumChan; c++) begin
      s_sa_a_d[c]  = {{ChanW{1'b0}}, src_i[c*ChanW +: ChanW]} * {{ChanW{1'b0}}, sa};
      d_inv_a_d[c] = {{ChanW{1'b0}}, dst_i[c*ChanW +: ChanW]} * {{ChanW{1'b0}}, inv};
      d_da_a_d[c]  = {{ChanW{1'b0}}, dst_i[c*ChanW +: ChanW]} * {{ChanW{1'b0}}, da};
    end
    da_inv_a_d = {{ChanW{1'b0}}, da} * {{ChanW{1'b0}}, inv};
  end

  // Stage B: output alpha, opaque mix and the triple product
  always_comb begin
    oa_sum = {1'b0, da_inv_a_q} + (ProdW+1)'(128);
    oa_b_d = sa_a_q + oa_sum[ProdW-1:ChanW];
    for (int c = 0; c < NumChan; c++) begin
      mix_sum[c] = {1'b0, s_sa_a_q[c]} + {1'b0, d_inv_a_q[c]} + (ProdW+1)'(128);
      mix_b_d[c*ChanW +: ChanW] = mix_sum[c][ProdW-1:ChanW];
      t_b_d[c] = {{ChanW{1'b0}}, d_da_a_q[c]} * {{ProdW{1'b0}}, inv_a_q};
    end
  end

  // Stage C: blend numerator plus half the divisor for rounding
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      t_rnd[c]   = {1'b0, t_b_q[c]} + (TriW+1)'(128);
      p_c[c]     = {{(NumW-ProdW){1'b0}}, s_sa_b_q[c]} + NumW'(t_rnd[c][TriW:ChanW]);
      num_c_d[c] = p_c[c] + {{(NumW-ChanW+1){1'b0}}, oa_b_q[ChanW-1:1]};
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
    end
  end

  // Hold the stage payloads
  always_ff @(posedge clk_i) begin
    kind_a_q   <= kind_a_d;
    src_a_q    <= src_i;
    dst_a_q    <= dst_i;
    sa_a_q     <= sa;
    inv_a_q    <= inv;
    s_sa_a_q   <= s_sa_a_d;
    d_inv_a_q  <= d_inv_a_d;
    d_da_a_q   <= d_da_a_d;
    da_inv_a_q <= da_inv_a_d;

    kind_b_q   <= kind_a_q;
    src_b_q    <= src_a_q;
    dst_b_q    <= dst_a_q;
    oa_b_q     <= oa_b_d;
    mix_b_q    <= mix_b_d;
    s_sa_b_q   <= s_sa_a_q;
    t_b_q      <= t_b_d;

    kind_c_q   <= kind_b_q;
    src_c_q    <= src_b_q;
    dst_c_q    <= dst_b_q;
    oa_c_q     <= oa_b_q;
    mix_c_q    <= mix_b_q;
    num_c_q    <= num_c_d;
  end

  // Hand the item to the divider
  always_comb begin
    stage_o.valid = valid_c_q;
    stage_o.kind  = kind_c_q;
    stage_o.src   = src_c_q;
    stage_o.dst   = dst_c_q;
    stage_o.oa    = oa_c_q;
    stage_o.mix   = mix_c_q;
    stage_o.rem   = num_c_q;
    stage_o.quo   = '0;
  end

endmodule

`default_nettype wire

// ===== rtl/core/amab_div.sv =====
// Pipelined restoring divider: divides each blend numerator by the output
// alpha, a few quotient bits per stage. Depends on amab_pkg.
`default_nettype none

module amab_div import amab_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  amab_div_t stage_i,
  output amab_div_t stage_o
);

  logic      vld_q [DivStages];
  amab_div_t pay_d [DivStages];
  amab_div_t pay_q [DivStages];

  // Try BitsPerStage quotient bits, highest first, on every channel
  function automatic amab_div_t div_steps(amab_div_t cur, int unsigned top_bit);
    amab_div_t       nxt;
    logic [NumW-1:0] dvs;
    int unsigned     b;
    nxt = cur;
    for (int c = 0; c < NumChan; c++) begin
      for (int k = 0; k < BitsPerStage; k++) begin
        b   = top_bit - k;
        dvs = {{(NumW-ChanW){1'b0}}, cur.oa} << b;
        if (nxt.rem[c] >= dvs) begin
          nxt.rem[c] = nxt.rem[c] - dvs;
          nxt.quo[c] = nxt.quo[c] | (QuoW'(1) << b);
        end
      end
    end
    return nxt;
  endfunction

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    amab_div_t in_s;
    logic      in_v;

    if (s == 0) begin : g_first
      assign in_s = stage_i;
      assign in_v = stage_i.valid;
    end else begin : g_next
      assign in_s = pay_q[s-1];
      assign in_v = vld_q[s-1];
    end

    // Resolve this stage's quotient bits
    always_comb begin
      pay_d[s] = div_steps(in_s, QuoW - 1 - s * BitsPerStage);
    end

    // Advance the valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= in_v;
      end
    end

    // Hold the partial remainders and quotients
    always_ff @(posedge clk_i) begin
      pay_q[s] <= pay_d[s];
    end
  end

  // Present the finished item with its valid bit
  always_comb begin
    stage_o       = pay_q[DivStages-1];
    stage_o.valid = vld_q[DivStages-1];
  end

endmodule

`default_nettype wire

// ===== rtl/core/argb_modulate_alpha_blend_core.sv =====
// ARGB8888 source-over compositor with optional color modulation.
// Depends on amab_pkg, amab_modulate, amab_mix and amab_div.
//
// Usage:
//   Input channel: drive in_item_i (source and destination pixel) and raise
//   start_i; the item is taken at every rising edge with start_i high and
//   busy_o low. busy_o stays low, so one pixel can enter every clock.
//   Result channel: result_valid_o is high for exactly one cycle per item,
//   with out_item_o holding the composited pixel and the write flag.
//   Results leave in input order at one per clock. The pipeline has one
//   modulation stage, three stages of products and sums, three divider
//   stages of three quotient bits each, and the output register.
//   Configuration: cfg_we_i writes cfg_wdata_i into the modulation color at
//   the next edge; write it only while no item is in flight.
//   Reset: clears all valid bits and sets the modulation color to all ones
//   (no modulation). The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module argb_modulate_alpha_blend_core import amab_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  amab_in_t        in_item_i,
  input  logic            cfg_we_i,
  input  logic [PixW-1:0] cfg_wdata_i,
  output logic            result_valid_o,
  output amab_out_t       out_item_o
);

  logic            accept;
  logic [PixW-1:0] mod_color_q;
  logic            mod_valid;
  logic [PixW-1:0] mod_src, mod_dst;
  amab_div_t       mix_out;
  amab_div_t       div_out;
  amab_out_t       out_item_d, out_item_q;
  logic            out_valid_q;

  // Take an item every cycle
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Modulation color register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_color_q <= ModBypass;
    end else if (cfg_we_i) begin
      mod_color_q <= cfg_wdata_i;
    end
  end

  amab_modulate u_modulate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .item_i      (in_item_i),
    .mod_color_i (mod_color_q),
    .valid_o     (mod_valid),
    .src_o       (mod_src),
    .dst_o       (mod_dst)
  );

  amab_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mod_valid),
    .src_i   (mod_src),
    .dst_i   (mod_dst),
    .stage_o (mix_out)
  );

  amab_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (mix_out),
    .stage_o (div_out)
  );

  // Select the composited pixel by case
  always_comb begin
    out_item_d.result_pixel = div_out.src;
    out_item_d.write_enable = 1'b1;
    unique case (div_out.kind)
      CASE_SKIP: begin
        out_item_d.result_pixel = div_out.dst;
        out_item_d.write_enable = 1'b0;
      end
      CASE_COPY: begin
        out_item_d.result_pixel = div_out.src;
      end
      CASE_OPAQUE: begin
        out_item_d.result_pixel = {AlphaFull, div_out.mix};
      end
      CASE_BLEND: begin
        out_item_d.result_pixel[PixW-1 -: ChanW] = div_out.oa;
        for (int c = 0; c < NumChan; c++) begin
          out_item_d.result_pixel[c*ChanW +: ChanW] = div_out.quo[c][ChanW-1:0];
        end
      end
      default: begin
        out_item_d.result_pixel = div_out.src;
      end
    endcase
  end

  // Output strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= div_out.valid;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign result_valid_o = out_valid_q;
  assign out_item_o     = out_item_q;

endmodule

`default_nettype wire

// ===== rtl/core/amab_checker.sv =====
// Port-level checks for argb_modulate_alpha_blend_core, bound to the top.
// Depends on amab_pkg.
`default_nettype none

module amab_checker import amab_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start_i,
  input logic            busy_o,
  input amab_in_t        in_item_i,
  input logic            result_valid_o,
  input amab_out_t       out_item_o
);

  localparam int unsigned Lat = AmabLatency;

  logic in_take;
  assign in_take = start_i && !busy_o;

  // Every taken item yields a result after the fixed latency
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |-> ##Lat result_valid_o)
    else $error("taken item produced no result");

  // No result without a taken item
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(in_take, Lat))
    else $error("result without a taken item");

  // A skipped write returns the destination unchanged
  a_skip_keeps_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !out_item_o.write_enable) |->
      (out_item_o.result_pixel == $past(in_item_i.dest_pixel, Lat)))
    else $error("skipped write with wrong pixel");

  // An opaque destination stays opaque when written
  a_opaque_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && out_item_o.write_enable &&
     ($past(in_item_i.dest_pixel[PixW-1 -: ChanW], Lat) == AlphaFull)) |->
      (out_item_o.result_pixel[PixW-1 -: ChanW] == AlphaFull))
    else $error("opaque destination lost its alpha");

endmodule

bind argb_modulate_alpha_blend_core amab_checker u_amab_checker (.*);

`default_nettype wire

// ===== verif/argb_modulate_alpha_blend_core_tb.sv =====
// Testbench for argb_modulate_alpha_blend_core: source-over compositing with color modulation.
// Depends on amab_pkg and the core RTL. A built-in predictor checks every result pixel.
`timescale 1ns / 1ps

module argb_modulate_alpha_blend_core_tb;
  import amab_pkg::*;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            start_i     = 1'b0;
  logic            busy_o;
  amab_in_t        in_item_i   = '0;
  logic            cfg_we_i    = 1'b0;
  logic [PixW-1:0] cfg_wdata_i = '0;
  logic            result_valid_o;
  amab_out_t       out_item_o;

  // Predictor copy of the modulation color, expected results in input order
  logic [PixW-1:0] mod_color_q = ModBypass;
  amab_out_t       expected_pixels[$];
  int unsigned     mismatch_count = 0;
  bit              no_idle = 1'b0;

  argb_modulate_alpha_blend_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .in_item_i      (in_item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .out_item_o     (out_item_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Compute the composited pixel and write flag for one source/destination pair
  function automatic amab_out_t blend_pixel(logic [PixW-1:0] src_px, logic [PixW-1:0] dst_px);
    amab_out_t   res;
    amab_case_e  kind;
    logic [PixW-1:0] s;
    int unsigned sa, da, oa, sc, dc, mc, p, v;
    int          k;
    s = src_px;
    // Scale each source channel by the modulation color unless bypassed
    if (mod_color_q != ModBypass) begin
      for (k = 0; k < NumAll; k++) begin
        sc = src_px[ChanW*k +: ChanW];
        mc = mod_color_q[ChanW*k +: ChanW];
        v  = (sc * mc + 128) >> 8;
        s[ChanW*k +: ChanW] = v[ChanW-1:0];
      end
    end
    sa = s[PixW-1 -: ChanW];
    da = dst_px[PixW-1 -: ChanW];
    if (sa == 0)        kind = CASE_SKIP;
    else if (sa == 255) kind = CASE_COPY;
    else if (da == 255) kind = CASE_OPAQUE;
    else                kind = CASE_BLEND;
    res.write_enable = (kind != CASE_SKIP);
    case (kind)
      CASE_SKIP: begin
        res.result_pixel = dst_px;
      end
      CASE_COPY: begin
        res.result_pixel = s;
      end
      CASE_OPAQUE: begin
        res.result_pixel = {AlphaFull, 24'h0};
        for (k = 0; k < NumChan; k++) begin
          sc = s[ChanW*k +: ChanW];
          dc = dst_px[ChanW*k +: ChanW];
          v  = (sc * sa + dc * (255 - sa) + 128) >> 8;
          res.result_pixel[ChanW*k +: ChanW] = v[ChanW-1:0];
        end
      end
      default: begin
        oa = sa + ((da * (255 - sa) + 128) >> 8);
        res.result_pixel = '0;
        res.result_pixel[PixW-1 -: ChanW] = oa[ChanW-1:0];
        for (k = 0; k < NumChan; k++) begin
          sc = s[ChanW*k +: ChanW];
          dc = dst_px[ChanW*k +: ChanW];
          p  = sc * sa + ((dc * da * (255 - sa) + 128) >> 8);
          v  = (p + oa / 2) / oa;
          res.result_pixel[ChanW*k +: ChanW] = v[ChanW-1:0];
        end
      end
    endcase
    return res;
  endfunction

  // Alpha values weighted toward the case boundaries
  function automatic logic [ChanW-1:0] pick_alpha();
    case ($urandom_range(5))
      0: return AlphaZero;
      1: return AlphaFull;
      2: return 8'h01;
      3: return 8'hFE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [PixW-1:0] pick_pixel();
    if ($urandom_range(3) == 0) return $urandom;
    return {pick_alpha(), 24'($urandom)};
  endfunction

  // Offer one item, idling at random before it, and record its expected result
  task automatic send_pixel(input logic [PixW-1:0] src_px, input logic [PixW-1:0] dst_px);
    while (!no_idle && $urandom_range(99) < 38) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i   <= 1'b1;
    in_item_i <= {src_px, dst_px};
    do @(posedge clk_i); while (busy_o);
    expected_pixels.push_back(blend_pixel(src_px, dst_px));
  endtask

  // Hold off the sender until every expected result has come
  task automatic drain_pipeline();
    start_i <= 1'b0;
    do @(posedge clk_i); while (expected_pixels.size() != 0);
  endtask

  task automatic write_mod_color(input logic [PixW-1:0] color);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= color;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mod_color_q  = color;
  endtask

  // Every compositing case and the alpha extremes without modulation
  task automatic test_directed_cases();
    send_pixel(32'h00FF_FFFF, 32'h1234_5678);   // transparent source
    send_pixel(32'h0000_0000, 32'h0000_0000);
    send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
    send_pixel(32'hFF00_0000, 32'hFFFF_FFFF);   // opaque source
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
    send_pixel(32'h80FF_8000, 32'hFF00_80FF);   // opaque destination
    send_pixel(32'h01FF_FFFF, 32'hFF00_0000);
    send_pixel(32'hFE00_0000, 32'hFFFF_FFFF);
    send_pixel(32'h80FF_0000, 32'h0000_0000);   // general blend, empty destination
    send_pixel(32'h01FF_FFFF, 32'h0000_0000);
    send_pixel(32'h0100_0000, 32'hFEFF_FFFF);
    send_pixel(32'hFEFF_FFFF, 32'hFE00_0000);
    send_pixel(32'h7F7F_7F7F, 32'h8080_8080);
    drain_pipeline();
  endtask

  // Modulation colors at and near the extremes
  task automatic test_modulation_extremes();
    write_mod_color(32'h0000_0000);              // every source becomes transparent
    send_pixel(32'hFFFF_FFFF, 32'h0102_0304);
    send_pixel(32'h8080_8080, 32'hFFFF_FFFF);
    drain_pipeline();
    write_mod_color(32'hFFFF_FFFE);              // one bit short of bypass
    send_pixel(32'hFFFF_FFFF, 32'h8080_8080);
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain_pipeline();
    write_mod_color(32'h80FF_00FF);
    send_pixel(32'hFF80_40C0, 32'h40C0_C0C0);
    send_pixel(32'h01FF_FFFF, 32'hFF12_3456);
    drain_pipeline();
    write_mod_color(32'hFF00_0000);
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(32'h80AB_CDEF, 32'h7F00_0000);
    drain_pipeline();
    write_mod_color(ModBypass);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
    drain_pipeline();
  endtask

  // Random pixels under a run of modulation settings, pausing now and then
  task automatic test_random_blend(input int unsigned items_per_color);
    logic [PixW-1:0] colors[6];
    int c;
    int unsigned n;
    colors[0] = ModBypass;
    colors[1] = 32'h0000_0000;
    colors[2] = 32'hFFFF_FFFE;
    colors[3] = $urandom;
    colors[4] = {AlphaFull, 24'($urandom)};
    colors[5] = $urandom;
    for (c = 0; c < 6; c++) begin
      write_mod_color(colors[c]);
      for (n = 0; n < items_per_color; n++) begin
        send_pixel(pick_pixel(), pick_pixel());
        if ($urandom_range(199) == 0) drain_pipeline();
      end
      drain_pipeline();
    end
  endtask

  // One item per clock with no idling at all
  task automatic test_back_to_back(input int unsigned count);
    int unsigned n;
    write_mod_color($urandom);
    no_idle = 1'b1;
    for (n = 0; n < count; n++) send_pixel(pick_pixel(), pick_pixel());
    no_idle = 1'b0;
    drain_pipeline();
    write_mod_color(ModBypass);
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    amab_out_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result: expected none, actual %h/%b", $time,
                 out_item_o.result_pixel, out_item_o.write_enable);
      end else begin
        want = expected_pixels.pop_front();
        if (out_item_o.result_pixel !== want.result_pixel) begin
          mismatch_count++;
          $display("%0t: result_pixel mismatch: expected %h, actual %h", $time,
                   want.result_pixel, out_item_o.result_pixel);
        end
        if (out_item_o.write_enable !== want.write_enable) begin
          mismatch_count++;
          $display("%0t: write_enable mismatch: expected %b, actual %b", $time,
                   want.write_enable, out_item_o.write_enable);
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_modulation_extremes();
    test_random_blend(230);
    test_back_to_back(120);
    drain_pipeline();
    repeat (AmabLatency + 4) @(posedge clk_i);
    if (expected_pixels.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, expected_pixels.size());
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("** argb_modulate_alpha_blend_core: PASSED **");
    end else begin
      $display("** argb_modulate_alpha_blend_core: FAILED **");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #400000;
    $display("** argb_modulate_alpha_blend_core: FAILED **");
    $finish;
  end

endmodule
